// ===== design/nspl_pkg.sv =====
package nspl_pkg;

  localparam int COORD_W   = 10;
  localparam int COLOR_W   = 32;
  localparam int GRID_W    = 11;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 6;
  localparam int PIX_W     = 20;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int CFG_IDX_W = 1;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SEEDS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OOB      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] rgb;
  } seed_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

// ===== design/nspl_if.sv =====
interface nspl_in_if;
  logic                           valid;
  logic                           ready;
  logic [nspl_pkg::MODE_W-1:0]    mode;
  logic [nspl_pkg::COORD_W-1:0]   coord_x;
  logic [nspl_pkg::COORD_W-1:0]   coord_y;
  logic [nspl_pkg::COLOR_W-1:0]   seed_color_in;

  modport source (output valid, mode, coord_x, coord_y, seed_color_in, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, seed_color_in, output ready);
endinterface

interface nspl_out_if;
  logic                            valid;
  logic                            ready;
  logic [nspl_pkg::STATUS_W-1:0]   status;
  logic [nspl_pkg::OUT_IDX_W-1:0]  nearest_index;
  logic [nspl_pkg::COLOR_W-1:0]    nearest_color;
  logic [nspl_pkg::PIX_W-1:0]      pixel_index;

  modport source (output valid, status, nearest_index, nearest_color, pixel_index,
                  input ready);
  modport sink   (input valid, status, nearest_index, nearest_color, pixel_index,
                  output ready);
endinterface

// ===== design/nspl_seed_mem.sv =====
module nspl_seed_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  nspl_pkg::seed_t       wdata,
  input  logic [AW-1:0]         raddr,
  output nspl_pkg::seed_t       rdata
);

  nspl_pkg::seed_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nspl_dist_unit.sv =====
module nspl_dist_unit #(
  parameter int IW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         tap_vld,
  input  logic [IW-1:0]                tap_idx,
  input  nspl_pkg::seed_t              tap,
  input  logic [nspl_pkg::COORD_W-1:0] px,
  input  logic [nspl_pkg::COORD_W-1:0] py,
  output logic                         busy,
  output logic [IW-1:0]                best_idx,
  output logic [nspl_pkg::COLOR_W-1:0] best_rgb
);

  logic [nspl_pkg::COORD_W-1:0]   dx, dy;
  logic [2*nspl_pkg::COORD_W-1:0] sx, sy;
  logic [nspl_pkg::DIST_W-1:0]    sq_dist;

  logic                           d_vld_r;
  logic [nspl_pkg::DIST_W-1:0]    d_r;
  logic [IW-1:0]                  d_idx_r;
  logic [nspl_pkg::COLOR_W-1:0]   d_rgb_r;

  logic                           have_r;
  logic [nspl_pkg::DIST_W-1:0]    best_d_r;
  logic [IW-1:0]                  best_idx_r;
  logic [nspl_pkg::COLOR_W-1:0]   best_rgb_r;
  logic                           take;

  // squared euclidean distance, registered before the compare
  always_comb begin
    dx      = (tap.col > px) ? (tap.col - px) : (px - tap.col);
    dy      = (tap.row > py) ? (tap.row - py) : (py - tap.row);
    sx      = (2*nspl_pkg::COORD_W)'(dx) * (2*nspl_pkg::COORD_W)'(dx);
    sy      = (2*nspl_pkg::COORD_W)'(dy) * (2*nspl_pkg::COORD_W)'(dy);
    sq_dist = {1'b0, sx} + {1'b0, sy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= tap_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= sq_dist;
    d_idx_r <= tap_idx;
    d_rgb_r <= tap.rgb;
  end

  // strict less-than keeps the earliest seed on a tie
  assign take = d_vld_r && (!have_r || (d_r < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (start) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_d_r   <= d_r;
      best_idx_r <= d_idx_r;
      best_rgb_r <= d_rgb_r;
    end
  end

  assign busy     = d_vld_r;
  assign best_idx = best_idx_r;
  assign best_rgb = best_rgb_r;

endmodule

// ===== design/nearest_seed_pixel_labeler_unit.sv =====
// nearest seed pixel labeler
// in_if carries one item per valid/ready handshake: mode, coord_x, coord_y and
// seed_color_in. out_if returns exactly one result item for each input item:
// status, nearest_index, nearest_color and pixel_index.
// cfg_we/cfg_index/cfg_data write grid_width (index 0) and grid_height (index 1);
// write them only while the block is idle.
// clear, add and unused-mode items, and items with an out-of-grid coordinate,
// pass from accept through the CALC state into the pending result register.
// a classify item sweeps every stored seed through one distance/compare unit,
// one seed per cycle from the seed memory read port.
// in_if.ready is high only while no item is in work; one finished item can
// sit in the output register while the next item is accepted and worked on.
// if the receiver stalls, the next finished item waits inside the block and
// in_if.ready stays low until the output register frees up.
// synchronous reset (rst_n low) empties the seed table, drops any pending
// result and sets both grid registers to 256; no memory sweep is needed.
module nearest_seed_pixel_labeler_unit #(
  parameter int MAX_SEEDS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  nspl_in_if.sink                           in_if,
  nspl_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [nspl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nspl_pkg::GRID_W-1:0]       cfg_data
);

  localparam int IW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = $clog2(MAX_SEEDS + 1);

  // control
  nspl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic             out_valid_r, out_valid_nxt;

  // item captured at accept
  logic [nspl_pkg::MODE_W-1:0]  mode_r;
  logic [nspl_pkg::COORD_W-1:0] x_r, y_r;
  logic [nspl_pkg::COLOR_W-1:0] color_r;

  // grid registers
  logic [nspl_pkg::GRID_W-1:0]  gw_r, gh_r;

  // pending result
  logic [nspl_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [nspl_pkg::OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [nspl_pkg::COLOR_W-1:0]   res_color_r, res_color_nxt;
  logic [nspl_pkg::PIX_W-1:0]     res_pix_r, res_pix_nxt;

  // output register
  logic [nspl_pkg::STATUS_W-1:0]  out_status_r;
  logic [nspl_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic [nspl_pkg::COLOR_W-1:0]   out_color_r;
  logic [nspl_pkg::PIX_W-1:0]     out_pix_r;

  logic                 in_accept;
  logic                 oob;
  logic                 full;
  logic [21:0]          pix_full;
  logic                 scan_issue;
  logic                 scan_end;
  logic                 load_out;
  logic                 mem_we;
  nspl_pkg::seed_t      mem_wdata;
  nspl_pkg::seed_t      mem_rdata;
  logic                 dist_busy;
  logic                 dist_start;
  logic [IW-1:0]        best_idx;
  logic [nspl_pkg::COLOR_W-1:0] best_rgb;
  logic [IW+nspl_pkg::OUT_IDX_W-1:0] best_idx_ext;
  logic [IW+nspl_pkg::OUT_IDX_W-1:0] add_idx_ext;

  assign in_if.ready = (state_r == nspl_pkg::ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r  <= in_if.mode;
      x_r     <= in_if.coord_x;
      y_r     <= in_if.coord_y;
      color_r <= in_if.seed_color_in;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= nspl_pkg::GRID_RESET;
      gh_r <= nspl_pkg::GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nspl_pkg::CFG_GRID_WIDTH:  gw_r <= cfg_data;
        nspl_pkg::CFG_GRID_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item decode: grid test, table-full test and linear pixel index
  assign oob      = ({1'b0, x_r} >= gw_r) || ({1'b0, y_r} >= gh_r);
  assign full     = (count_r == CW'(MAX_SEEDS));
  assign pix_full = (22'(y_r) * 22'(gw_r)) + 22'(x_r);

  assign add_idx_ext  = {{nspl_pkg::OUT_IDX_W{1'b0}}, count_r[IW-1:0]};
  assign best_idx_ext = {{nspl_pkg::OUT_IDX_W{1'b0}}, best_idx};

  // seed sweep: one read per cycle, memory and distance stages drain after the last
  assign scan_issue = (state_r == nspl_pkg::ST_SCAN) && (ptr_r < count_r);
  assign scan_end   = (state_r == nspl_pkg::ST_SCAN) && (ptr_r >= count_r)
                      && !rd_vld_r && !dist_busy;
  assign dist_start = (state_r == nspl_pkg::ST_CALC);

  assign mem_we    = (state_r == nspl_pkg::ST_CALC) && (mode_r == nspl_pkg::MODE_ADD)
                     && !oob && !full;
  assign mem_wdata = '{col: x_r, row: y_r, rgb: color_r};

  assign load_out = (state_r == nspl_pkg::ST_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_color_nxt  = res_color_r;
    res_pix_nxt    = res_pix_r;
    unique case (state_r)
      nspl_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = nspl_pkg::ST_CALC;
        end
      end
      nspl_pkg::ST_CALC: begin
        res_status_nxt = nspl_pkg::STAT_OK;
        res_idx_nxt    = '0;
        res_color_nxt  = '0;
        res_pix_nxt    = '0;
        state_nxt      = nspl_pkg::ST_DONE;
        priority if (mode_r == nspl_pkg::MODE_CLEAR) begin
          count_nxt = '0;
        end else if (mode_r == nspl_pkg::MODE_UNUSED) begin
          // nothing changes, all-zero result
        end else if (oob) begin
          res_status_nxt = nspl_pkg::STAT_OOB;
        end else if (mode_r == nspl_pkg::MODE_ADD) begin
          res_pix_nxt = pix_full[nspl_pkg::PIX_W-1:0];
          if (full) begin
            res_status_nxt = nspl_pkg::STAT_FULL;
          end else begin
            res_idx_nxt   = add_idx_ext[nspl_pkg::OUT_IDX_W-1:0];
            res_color_nxt = color_r;
            count_nxt     = count_r + CW'(1);
          end
        end else begin
          // classify
          res_pix_nxt = pix_full[nspl_pkg::PIX_W-1:0];
          if (count_r == '0) begin
            res_status_nxt = nspl_pkg::STAT_NO_SEEDS;
          end else begin
            ptr_nxt   = '0;
            state_nxt = nspl_pkg::ST_SCAN;
          end
        end
      end
      nspl_pkg::ST_SCAN: begin
        if (scan_issue) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (scan_end) begin
          res_idx_nxt   = best_idx_ext[nspl_pkg::OUT_IDX_W-1:0];
          res_color_nxt = best_rgb;
          state_nxt     = nspl_pkg::ST_DONE;
        end
      end
      nspl_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = nspl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nspl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nspl_pkg::ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= scan_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= ptr_r[IW-1:0];
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_color_r  <= res_color_nxt;
    res_pix_r    <= res_pix_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_color_r  <= res_color_r;
      out_pix_r    <= res_pix_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.nearest_index = out_idx_r;
  assign out_if.nearest_color = out_color_r;
  assign out_if.pixel_index   = out_pix_r;

  nspl_seed_mem #(
    .DEPTH (MAX_SEEDS),
    .AW    (IW)
  ) u_seed_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IW-1:0]),
    .wdata (mem_wdata),
    .raddr (ptr_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  nspl_dist_unit #(
    .IW (IW)
  ) u_dist_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .tap_vld  (rd_vld_r),
    .tap_idx  (rd_idx_r),
    .tap      (mem_rdata),
    .px       (x_r),
    .py       (y_r),
    .busy     (dist_busy),
    .best_idx (best_idx),
    .best_rgb (best_rgb)
  );

endmodule
